>>> design/sqwt_pkg.sv
// ----------------------------------------------------------------------------
// sqwt_pkg
// shared types and codes for the sleep queue wake-up timer
// ----------------------------------------------------------------------------
package sqwt_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_WOKEN      = 2'd0,
    ST_QUEUED     = 2'd1,
    ST_NOT_QUEUED = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // input kinds carried on s_tuser
  localparam logic MODE_SLEEP = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_t;

  // configuration register map
  localparam int    ADDR_W         = 3;
  localparam logic  REG_IDLE_INDEX = 1'b0;
  localparam int    DUR_W          = 32;
  localparam int    TIME_W         = 64;
  localparam int    CFG_W          = 32;

endpackage

>>> design/sleep_queue_wakeup_timer_unit.sv
// a sleep result waits in the pending register until the output is free, then the unit is
// free; a tick advances the counter, then reads each stored sleeper, compares it and writes
// back survivors, then presents the final woken beat, if any; woken beats leave through one
// output register; the scan stalls on a due sleeper while a beat waits and it is occupied
// reset (rst, synchronous, active high) zeroes the tick counter, the fill count and the
// idle id; the table memory is not cleared, the fill count marks which entries are live
// ----------------------------------------------------------------------------
// sleep_queue_wakeup_timer_unit
// sleep list with absolute wake times and a tick driven wake-up scan
// ----------------------------------------------------------------------------
module sleep_queue_wakeup_timer_unit #(
  parameter int MAX_SLEEPERS = 16,
  parameter int ID_BITS      = 6
) (
  input  logic clk,
  input  logic rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sqwt_pkg::ADDR_W-1:0] paddr,
  input  logic [sqwt_pkg::CFG_W-1:0]  pwdata,
  output logic [sqwt_pkg::CFG_W-1:0]  prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // s_tdata: thread_id, duration, zero padding
  input  logic [((ID_BITS+sqwt_pkg::DUR_W+7)/8)*8-1:0] s_tdata,
  // s_tuser: mode
  input  logic                        s_tuser,
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // m_tdata: result_id, zero padding
  output logic [((ID_BITS+7)/8)*8-1:0] m_tdata,
  // m_tuser: status
  output logic [1:0]                  m_tuser,
  output logic                        m_tlast
);

  localparam int IDX_W  = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLEEPERS + 1);
  localparam int DATA_W = ID_BITS + sqwt_pkg::TIME_W;
  localparam int OUT_W  = ((ID_BITS + 7) / 8) * 8;

  logic [ID_BITS-1:0] idle_id;
  logic               cfg_write;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  rd_data;
  sqwt_pkg::status_t  out_status;
  logic [ID_BITS-1:0] out_id;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_id <= '0;
    end else if (cfg_write && paddr[2] == sqwt_pkg::REG_IDLE_INDEX) begin
      idle_id <= pwdata[ID_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == sqwt_pkg::REG_IDLE_INDEX) begin
      prdata = sqwt_pkg::CFG_W'(idle_id);
    end
  end

  // result packing
  assign m_tdata = OUT_W'(out_id);
  assign m_tuser = out_status;

  sqwt_ctrl #(
    .MAX_SLEEPERS (MAX_SLEEPERS),
    .ID_BITS      (ID_BITS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .idle_id     (idle_id),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser),
    .in_id       (s_tdata[ID_BITS-1:0]),
    .in_duration (s_tdata[ID_BITS+sqwt_pkg::DUR_W-1:ID_BITS]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (out_status),
    .out_id      (out_id),
    .out_last    (m_tlast),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  sqwt_mem #(
    .DEPTH  (MAX_SLEEPERS),
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> design/sqwt_mem.sv
// ----------------------------------------------------------------------------
// sqwt_mem
// sleeper table: one write port, one registered read port
// ----------------------------------------------------------------------------
module sqwt_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 70
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered: data is valid in the cycle after the request
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/sqwt_ctrl.sv
// ----------------------------------------------------------------------------
// sqwt_ctrl
// tick counter, fill count and the sequencer that queues and wakes sleepers
// ----------------------------------------------------------------------------
module sqwt_ctrl #(
  parameter int MAX_SLEEPERS = 16,
  parameter int ID_BITS      = 6,
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ID_BITS-1:0]    idle_id,
  // input beat
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [ID_BITS-1:0]    in_id,
  input  logic [sqwt_pkg::DUR_W-1:0] in_duration,
  // result beat
  output logic                  out_valid,
  input  logic                  out_ready,
  output sqwt_pkg::status_t     out_status,
  output logic [ID_BITS-1:0]    out_id,
  output logic                  out_last,
  // table memory
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [ID_BITS+sqwt_pkg::TIME_W-1:0] wr_data,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [ID_BITS+sqwt_pkg::TIME_W-1:0] rd_data
);

  localparam int TW = sqwt_pkg::TIME_W;

  sqwt_pkg::state_t  state, state_next;
  logic [TW-1:0]     tick, tick_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  scan_idx, scan_idx_next;
  logic [CNT_W-1:0]  keep, keep_next;
  logic              pend_valid, pend_valid_next;
  sqwt_pkg::status_t pend_status, pend_status_next;
  logic [ID_BITS-1:0] pend_id, pend_id_next;
  logic              out_valid_next;
  sqwt_pkg::status_t out_status_next;
  logic [ID_BITS-1:0] out_id_next;
  logic              out_last_next;

  logic              out_free;
  logic              positive;
  logic [TW-1:0]     entry_wake;
  logic [ID_BITS-1:0] entry_id;
  logic              due;
  logic              scan_end;

  assign out_free   = !out_valid || out_ready;
  assign positive   = (in_duration != '0) && !in_duration[sqwt_pkg::DUR_W-1];
  assign entry_wake = rd_data[TW-1:0];
  assign entry_id   = rd_data[ID_BITS+TW-1:TW];
  assign due        = entry_wake <= tick;
  assign scan_end   = (scan_idx + CNT_W'(1)) == count;
  assign in_ready   = (state == sqwt_pkg::S_IDLE);
  assign rd_addr    = scan_idx[IDX_W-1:0];

  // next state and datapath
  always_comb begin
    state_next       = state;
    tick_next        = tick;
    count_next       = count;
    scan_idx_next    = scan_idx;
    keep_next        = keep;
    pend_valid_next  = pend_valid;
    pend_status_next = pend_status;
    pend_id_next     = pend_id;
    out_valid_next   = out_valid && !out_ready;
    out_status_next  = out_status;
    out_id_next      = out_id;
    out_last_next    = out_last;
    wr_en            = 1'b0;
    wr_addr          = count[IDX_W-1:0];
    wr_data          = {in_id, tick + {{(TW-sqwt_pkg::DUR_W){1'b0}}, in_duration}};
    rd_en            = 1'b0;

    case (state)
      sqwt_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_mode == sqwt_pkg::MODE_SLEEP) begin
            // sleep request: one result, held until the output is free
            pend_valid_next = 1'b1;
            pend_id_next    = in_id;
            state_next      = sqwt_pkg::S_FLUSH;
            if (in_id == idle_id || !positive) begin
              pend_status_next = sqwt_pkg::ST_NOT_QUEUED;
            end else if (count == CNT_W'(MAX_SLEEPERS)) begin
              pend_status_next = sqwt_pkg::ST_FULL;
            end else begin
              pend_status_next = sqwt_pkg::ST_QUEUED;
              wr_en            = 1'b1;
              count_next       = count + CNT_W'(1);
            end
          end else begin
            // tick: advance the counter, then scan the table
            tick_next       = tick + TW'(1);
            scan_idx_next   = '0;
            keep_next       = '0;
            pend_valid_next = 1'b0;
            if (count != '0) begin
              state_next = sqwt_pkg::S_READ;
            end
          end
        end
      end

      sqwt_pkg::S_READ: begin
        rd_en      = 1'b1;
        state_next = sqwt_pkg::S_EVAL;
      end

      sqwt_pkg::S_EVAL: begin
        if (due && pend_valid && !out_free) begin
          // previous woken result still waiting for room
          state_next = sqwt_pkg::S_EVAL;
        end else begin
          if (due) begin
            if (pend_valid) begin
              out_valid_next  = 1'b1;
              out_status_next = pend_status;
              out_id_next     = pend_id;
              out_last_next   = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_status_next = sqwt_pkg::ST_WOKEN;
            pend_id_next     = entry_id;
          end else begin
            // compact the survivors towards the head of the table
            wr_en     = 1'b1;
            wr_addr   = keep[IDX_W-1:0];
            wr_data   = rd_data;
            keep_next = keep + CNT_W'(1);
          end
          scan_idx_next = scan_idx + CNT_W'(1);
          if (scan_end) begin
            count_next = keep_next;
            if (pend_valid_next) begin
              state_next = sqwt_pkg::S_FLUSH;
            end else begin
              state_next = sqwt_pkg::S_IDLE;
            end
          end else begin
            state_next = sqwt_pkg::S_READ;
          end
        end
      end

      sqwt_pkg::S_FLUSH: begin
        // final result of the item carries last
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = pend_status;
          out_id_next     = pend_id;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = sqwt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sqwt_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sqwt_pkg::S_IDLE;
      tick       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      tick       <= tick_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx    <= scan_idx_next;
    keep        <= keep_next;
    pend_status <= pend_status_next;
    pend_id     <= pend_id_next;
    out_status  <= out_status_next;
    out_id      <= out_id_next;
    out_last    <= out_last_next;
  end

endmodule
